[rtl/vdi_pkg.sv]
`default_nettype none

package vdi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COMP_N       = 8;
    localparam int COMP_W       = 24;
    localparam int TOL_W        = 23;
    localparam int LANE_N       = 3;
    localparam int IN_LANE_W    = 16;
    localparam int SUM_LANE_W   = 20;
    localparam int OUT_IDX_W    = 10;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

    typedef struct packed {
        logic                                 mesh_start;
        logic signed [COMP_W-1:0]             position_x;
        logic signed [COMP_W-1:0]             position_y;
        logic signed [COMP_W-1:0]             position_z;
        logic signed [COMP_W-1:0]             tex_u;
        logic signed [COMP_W-1:0]             tex_v;
        logic signed [COMP_W-1:0]             normal_x;
        logic signed [COMP_W-1:0]             normal_y;
        logic signed [COMP_W-1:0]             normal_z;
        logic [LANE_N*IN_LANE_W-1:0]          tangent_in;
        logic [LANE_N*IN_LANE_W-1:0]          bitangent_in;
    } t_vdi_in;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]                 vertex_index;
        logic                                 is_new;
        logic                                 table_full;
        logic [LANE_N*SUM_LANE_W-1:0]         tangent_sum;
        logic [LANE_N*SUM_LANE_W-1:0]         bitangent_sum;
    } t_vdi_out;

endpackage

`default_nettype wire

[rtl/vdi_in_if.sv]
`default_nettype none

interface vdi_in_if;
    logic             valid;
    logic             ready;
    vdi_pkg::t_vdi_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/vdi_out_if.sv]
`default_nettype none

interface vdi_out_if;
    logic              valid;
    logic              ready;
    vdi_pkg::t_vdi_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/vertex_dedup_indexer_core.sv]
// Channel    Dir  Handshake      Payload
// i_vtx      in   valid/ready    one vertex: mesh_start, 8 Q8.16 components, tangent, bitangent
// o_res      out  valid/ready    vertex_index, is_new, table_full, tangent_sum, bitangent_sum
// i_cfg_we   in   write enable   i_cfg_wdata = match_tolerance
//
// One vertex compares the stored entries in order, through the first match or up to the
// table fill of 1024; an empty table goes straight to the append step.
// The shared compare unit checks one stored entry per cycle from the component memory's
// single read port.
// Reset (synchronous, active low) empties the table and sets the tolerance to 655.
// i_vtx is ready only when idle; a finished result waits in the output register
// and a result held there stalls the next one at its last step.
`default_nettype none

module vertex_dedup_indexer_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [vdi_pkg::TOL_W-1:0] i_cfg_wdata,
    vdi_in_if.sink                         i_vtx,
    vdi_out_if.source                      o_res
);
    import vdi_pkg::*;

    typedef logic [COMP_N-1:0][COMP_W-1:0]         t_comps;
    typedef logic [LANE_N-1:0][SUM_LANE_W-1:0]     t_sum;
    typedef logic [LANE_N-1:0][IN_LANE_W-1:0]      t_tan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUM_RD,
        S_SUM_ADD,
        S_APPEND,
        S_DONE
    } t_state;

    function automatic t_sum seed_sum(input t_tan v);
        t_sum r;
        for (int k = 0; k < LANE_N; k++) begin
            r[k] = SUM_LANE_W'(signed'(v[k]));
        end
        return r;
    endfunction

    function automatic t_sum add_sum(input t_sum s, input t_tan v);
        t_sum                      r;
        logic signed [SUM_LANE_W:0] t;
        for (int k = 0; k < LANE_N; k++) begin
            t = (SUM_LANE_W+1)'(signed'(s[k])) + (SUM_LANE_W+1)'(signed'(v[k]));
            if (t[SUM_LANE_W] == t[SUM_LANE_W-1]) begin
                r[k] = t[SUM_LANE_W-1:0];
            end else if (t[SUM_LANE_W]) begin
                r[k] = {1'b1, {(SUM_LANE_W-1){1'b0}}};
            end else begin
                r[k] = {1'b0, {(SUM_LANE_W-1){1'b1}}};
            end
        end
        return r;
    endfunction

    t_comps                comp_mem [MAX_VERTICES];
    logic [2*LANE_N*SUM_LANE_W-1:0] sum_mem [MAX_VERTICES];

    t_state                r_state;
    logic [TOL_W-1:0]      r_tol;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_scan;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_idx;
    logic [IDX_W-1:0]      r_hit_idx;
    t_vdi_in               r_in;
    t_comps                r_comp_q;
    t_sum                  r_tan_q;
    t_sum                  r_btan_q;
    t_vdi_out              r_res;
    t_vdi_out              r_out;
    logic                  r_out_valid;

    t_comps                in_comps;
    logic [COMP_N-1:0]     near;
    logic                  hit;
    logic                  rd_issue;
    t_sum                  tan_add;
    t_sum                  btan_add;
    t_sum                  tan_seed;
    t_sum                  btan_seed;

    assign in_comps = {r_in.normal_z, r_in.normal_y, r_in.normal_x, r_in.tex_v,
                       r_in.tex_u, r_in.position_z, r_in.position_y, r_in.position_x};

    always_comb begin
        logic signed [COMP_W:0] d;
        logic [COMP_W:0]        a;
        for (int k = 0; k < COMP_N; k++) begin
            d = (COMP_W+1)'(signed'(in_comps[k])) - (COMP_W+1)'(signed'(r_comp_q[k]));
            a = d[COMP_W] ? (COMP_W+1)'(-d) : d;
            near[k] = (a < (COMP_W+1)'(r_tol));
        end
    end

    assign hit      = r_pend && (&near);
    assign rd_issue = (r_state == S_SCAN) && (r_scan < r_count) && !hit;

    assign tan_add   = add_sum(r_tan_q, t_tan'(r_in.tangent_in));
    assign btan_add  = add_sum(r_btan_q, t_tan'(r_in.bitangent_in));
    assign tan_seed  = seed_sum(t_tan'(r_in.tangent_in));
    assign btan_seed = seed_sum(t_tan'(r_in.bitangent_in));

    assign i_vtx.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_comp_q <= comp_mem[r_scan[IDX_W-1:0]];
        end
        if (r_state == S_APPEND && r_count < CNT_W'(MAX_VERTICES)) begin
            comp_mem[r_count[IDX_W-1:0]] <= in_comps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM_RD) begin
            {r_btan_q, r_tan_q} <= sum_mem[r_hit_idx];
        end
        if (r_state == S_SUM_ADD) begin
            sum_mem[r_hit_idx] <= {btan_add, tan_add};
        end else if (r_state == S_APPEND && r_count < CNT_W'(MAX_VERTICES)) begin
            sum_mem[r_count[IDX_W-1:0]] <= {btan_seed, tan_seed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= TOL_RESET;
            r_count     <= '0;
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        r_in   <= i_vtx.data;
                        r_scan <= '0;
                        r_pend <= 1'b0;
                        if (i_vtx.data.mesh_start) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend     <= rd_issue;
                    r_pend_idx <= r_scan[IDX_W-1:0];
                    if (rd_issue) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (hit) begin
                        r_hit_idx <= r_pend_idx;
                        r_state   <= S_SUM_RD;
                    end else if (!rd_issue && !r_pend) begin
                        r_state <= S_APPEND;
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ADD;
                end
                S_SUM_ADD: begin
                    r_res.vertex_index  <= OUT_IDX_W'(r_hit_idx);
                    r_res.is_new        <= 1'b0;
                    r_res.table_full    <= 1'b0;
                    r_res.tangent_sum   <= tan_add;
                    r_res.bitangent_sum <= btan_add;
                    r_state             <= S_DONE;
                end
                S_APPEND: begin
                    if (r_count < CNT_W'(MAX_VERTICES)) begin
                        r_res.vertex_index  <= OUT_IDX_W'(r_count);
                        r_res.is_new        <= 1'b1;
                        r_res.table_full    <= 1'b0;
                        r_res.tangent_sum   <= tan_seed;
                        r_res.bitangent_sum <= btan_seed;
                        r_count             <= r_count + 1'b1;
                    end else begin
                        r_res <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1,
                                   tangent_sum: '0, bitangent_sum: '0};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("entry count above table depth");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM_RD) |-> ({1'b0, r_hit_idx} < r_count))
        else $error("matched index outside filled table");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND && r_count < CNT_W'(MAX_VERTICES))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance entry count");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved to output register");
`endif

endmodule

`default_nettype wire

[dv/tb_vertex_dedup_indexer_core.sv]
`default_nettype none

module tb_vertex_dedup_indexer_core;
    import vdi_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MESH_CAP    = 60;
    localparam int BURST_LEN   = 18;
    localparam int COMP_HI     = 2 ** (COMP_W - 1) - 1;
    localparam int COMP_LO     = -(2 ** (COMP_W - 1));
    localparam int SUM_HI      = 2 ** (SUM_LANE_W - 1) - 1;
    localparam int SUM_LO      = -(2 ** (SUM_LANE_W - 1));

    localparam logic [COMP_W-1:0]    COMP_MAX = 24'h7FFFFF;
    localparam logic [COMP_W-1:0]    COMP_MIN = 24'h800000;
    localparam logic [IN_LANE_W-1:0] LANE_MAX = 16'h7FFF;
    localparam logic [IN_LANE_W-1:0] LANE_MIN = 16'h8000;
    localparam logic [TOL_W-1:0]     TOL_MAX  = 23'h7FFFFF;

    localparam t_vdi_out FULL_RESULT = '{10'd0, 1'b0, 1'b1, 60'h0, 60'h0};

    typedef enum int unsigned {
        COMP_POS_X, COMP_POS_Y, COMP_POS_Z, COMP_TEX_U,
        COMP_TEX_V, COMP_NRM_X, COMP_NRM_Y, COMP_NRM_Z
    } t_comp_sel;

    typedef logic signed [COMP_W-1:0] t_comp_vec [COMP_N];

    typedef struct packed {
        int unsigned                 reps;
        bit                          start;
        logic [COMP_W-1:0]           base;
        t_comp_sel                   poke;
        logic [COMP_W-1:0]           poke_val;
        logic [LANE_N*IN_LANE_W-1:0] tan;
        logic [LANE_N*IN_LANE_W-1:0] bitan;
        bit                          typed;
        t_vdi_out                    want;
    } t_vertex_row;

    localparam int ROW_N = 11;
    localparam t_vertex_row VERTEX_ROWS [ROW_N] = '{
        '{1,  1, 24'h000000, COMP_POS_X, 24'h000000, 48'h0, 48'h0,
          1, '{10'd0, 1'b1, 1'b0, 60'h0, 60'h0}},
        '{1,  0, 24'h000000, COMP_POS_X, 24'h00028E, 48'h1, 48'h0,
          1, '{10'd0, 1'b0, 1'b0, 60'h1, 60'h0}},
        '{1,  0, 24'h000000, COMP_POS_X, 24'hFFFD72, 48'h0001_FFFF_0002, 48'h0,
          0, '0},
        '{1,  0, 24'h000000, COMP_TEX_V, 24'h00028F, 48'h0003_0002_0001, 48'h0,
          1, '{10'd1, 1'b1, 1'b0, 60'h00003_00002_00001, 60'h0}},
        '{1,  0, 24'h000000, COMP_TEX_V, 24'h00012C, 48'h0, 48'h0001_0001_0001,
          0, '0},
        '{1,  0, 24'h7FFFFF, COMP_POS_X, 24'h7FFFFF, 48'h7FFF_7FFF_7FFF,
          48'h8000_8000_8000,
          1, '{10'd2, 1'b1, 1'b0, 60'h07FFF_07FFF_07FFF, 60'hF8000_F8000_F8000}},
        '{1,  0, 24'h800000, COMP_POS_X, 24'h800000, 48'h0, 48'h0,
          1, '{10'd3, 1'b1, 1'b0, 60'h0, 60'h0}},
        '{16, 0, 24'h7FFFFF, COMP_POS_X, 24'h7FFFFF, 48'h7FFF_7FFF_7FFF,
          48'h8000_8000_8000, 0, '0},
        '{1,  0, 24'h800000, COMP_POS_X, 24'h800000, 48'h8000_8000_8000,
          48'h7FFF_7FFF_7FFF, 0, '0},
        '{1,  0, 24'h800000, COMP_NRM_Z, 24'h7FFFFF, 48'hFFFF_FFFF_FFFF, 48'h0,
          0, '0},
        '{1,  1, 24'h7FFFFF, COMP_POS_X, 24'h7FFFFF, 48'h0, 48'h0,
          1, '{10'd0, 1'b1, 1'b0, 60'h0, 60'h0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [TOL_W-1:0]     i_cfg_wdata;

    vdi_in_if  vtx_bus ();
    vdi_out_if res_bus ();

    vertex_dedup_indexer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vtx       (vtx_bus),
        .o_res       (res_bus)
    );

    logic signed [COMP_W-1:0]       uniq_comp [COMP_N][MAX_VERTICES];
    logic [LANE_N*SUM_LANE_W-1:0]   uniq_tan_sum [MAX_VERTICES];
    logic [LANE_N*SUM_LANE_W-1:0]   uniq_bitan_sum [MAX_VERTICES];
    int unsigned                    uniq_count = 0;
    logic [TOL_W-1:0]               match_tol = TOL_RESET;

    t_vdi_out    indexed_vertices [$];
    t_vdi_in     mesh_pool [$];
    int unsigned since_start = 0;
    int unsigned src_idle_pct = 20;
    int unsigned rcv_idle_pct = 71;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("vertex_dedup_indexer_core test failed");
            $finish;
        end
    end

    function automatic void split_comps(input t_vdi_in v, output t_comp_vec c);
        c[COMP_POS_X] = v.position_x;
        c[COMP_POS_Y] = v.position_y;
        c[COMP_POS_Z] = v.position_z;
        c[COMP_TEX_U] = v.tex_u;
        c[COMP_TEX_V] = v.tex_v;
        c[COMP_NRM_X] = v.normal_x;
        c[COMP_NRM_Y] = v.normal_y;
        c[COMP_NRM_Z] = v.normal_z;
    endfunction

    function automatic t_vdi_in join_comps(input t_vdi_in v, input t_comp_vec c);
        t_vdi_in r;
        r = v;
        r.position_x = c[COMP_POS_X];
        r.position_y = c[COMP_POS_Y];
        r.position_z = c[COMP_POS_Z];
        r.tex_u      = c[COMP_TEX_U];
        r.tex_v      = c[COMP_TEX_V];
        r.normal_x   = c[COMP_NRM_X];
        r.normal_y   = c[COMP_NRM_Y];
        r.normal_z   = c[COMP_NRM_Z];
        return r;
    endfunction

    function automatic logic [LANE_N*SUM_LANE_W-1:0] accumulate_lanes(
        input logic [LANE_N*SUM_LANE_W-1:0] sum,
        input logic [LANE_N*IN_LANE_W-1:0]  addend
    );
        logic [LANE_N*SUM_LANE_W-1:0] r;
        logic signed [SUM_LANE_W-1:0] a;
        logic signed [IN_LANE_W-1:0]  b;
        int                           s;
        int                           k;
        r = '0;
        for (k = 0; k < LANE_N; k++) begin
            a = sum[k*SUM_LANE_W +: SUM_LANE_W];
            b = addend[k*IN_LANE_W +: IN_LANE_W];
            s = a + b;
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            r[k*SUM_LANE_W +: SUM_LANE_W] = s[SUM_LANE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_vdi_out index_vertex(input t_vdi_in v);
        t_vdi_out  r;
        t_comp_vec c;
        longint    d;
        bit        near;
        bit        found;
        int        hit;
        int        i;
        int        k;
        r = '0;
        found = 1'b0;
        hit = 0;
        if (v.mesh_start) uniq_count = 0;
        split_comps(v, c);
        for (i = 0; i < int'(uniq_count) && !found; i++) begin
            near = 1'b1;
            for (k = 0; k < COMP_N; k++) begin
                d = longint'(c[k]) - longint'(uniq_comp[k][i]);
                if (d < 0) d = -d;
                if (!(d < longint'(match_tol))) near = 1'b0;
            end
            if (near) begin
                found = 1'b1;
                hit = i;
            end
        end
        if (found) begin
            uniq_tan_sum[hit]   = accumulate_lanes(uniq_tan_sum[hit], v.tangent_in);
            uniq_bitan_sum[hit] = accumulate_lanes(uniq_bitan_sum[hit], v.bitangent_in);
            r.vertex_index  = hit[OUT_IDX_W-1:0];
            r.tangent_sum   = uniq_tan_sum[hit];
            r.bitangent_sum = uniq_bitan_sum[hit];
        end else if (uniq_count < MAX_VERTICES) begin
            for (k = 0; k < COMP_N; k++) uniq_comp[k][uniq_count] = c[k];
            uniq_tan_sum[uniq_count]   = accumulate_lanes('0, v.tangent_in);
            uniq_bitan_sum[uniq_count] = accumulate_lanes('0, v.bitangent_in);
            r.vertex_index  = uniq_count[OUT_IDX_W-1:0];
            r.is_new        = 1'b1;
            r.tangent_sum   = uniq_tan_sum[uniq_count];
            r.bitangent_sum = uniq_bitan_sum[uniq_count];
            uniq_count++;
        end else begin
            r = FULL_RESULT;
        end
        return r;
    endfunction

    function automatic logic signed [COMP_W-1:0] offset_comp(
        input logic signed [COMP_W-1:0] c,
        input int                       delta
    );
        int x;
        x = int'(c) + delta;
        if (x > COMP_HI) x = COMP_HI;
        if (x < COMP_LO) x = COMP_LO;
        return x[COMP_W-1:0];
    endfunction

    function automatic logic [LANE_N*IN_LANE_W-1:0] random_lanes();
        logic [LANE_N*IN_LANE_W-1:0] r;
        int                          k;
        r = {16'($urandom()), 32'($urandom())};
        if ($urandom_range(99) < 30) begin
            for (k = 0; k < LANE_N; k++) begin
                case ($urandom_range(2))
                    0: r[k*IN_LANE_W +: IN_LANE_W] = LANE_MAX;
                    1: r[k*IN_LANE_W +: IN_LANE_W] = LANE_MIN;
                    default: r[k*IN_LANE_W +: IN_LANE_W] = 16'($urandom());
                endcase
            end
        end
        return r;
    endfunction

    function automatic t_vdi_in raw_vertex();
        t_vdi_in   v;
        t_comp_vec c;
        int        k;
        int        roll;
        v = '0;
        for (k = 0; k < COMP_N; k++) begin
            roll = $urandom_range(9);
            if (roll == 0) c[k] = COMP_MAX;
            else if (roll == 1) c[k] = COMP_MIN;
            else c[k] = 24'($urandom());
        end
        v = join_comps(v, c);
        v.tangent_in   = random_lanes();
        v.bitangent_in = random_lanes();
        return v;
    endfunction

    function automatic t_vdi_in random_vertex();
        t_vdi_in   v;
        t_comp_vec o;
        t_comp_vec c;
        int        roll;
        int        span;
        int        pick;
        int        delta;
        int        k;
        roll = $urandom_range(99);
        if (mesh_pool.size() == 0 || since_start >= MESH_CAP || roll < 4) begin
            v = raw_vertex();
            v.mesh_start = 1'b1;
            mesh_pool.delete();
            since_start = 0;
        end else if (roll < 80) begin
            v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
            v.mesh_start = 1'b0;
            split_comps(v, o);
            span = (match_tol == 0) ? 0 : int'(match_tol) - 1;
            for (k = 0; k < COMP_N; k++)
                c[k] = offset_comp(o[k], int'($urandom_range(2 * span)) - span);
            if (roll >= 56) begin
                pick = $urandom_range(COMP_N - 1);
                delta = int'(match_tol) - 1 + int'($urandom_range(2));
                if ($urandom_range(1)) delta = -delta;
                c[pick] = offset_comp(o[pick], delta);
            end
            v = join_comps(v, c);
            v.tangent_in   = random_lanes();
            v.bitangent_in = random_lanes();
        end else begin
            v = raw_vertex();
        end
        mesh_pool = {mesh_pool, v};
        since_start++;
        return v;
    endfunction

    function automatic void check_field(
        input string       name,
        input logic [63:0] want,
        input logic [63:0] got
    );
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_vdi_out want;
        t_vdi_out got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = res_bus.data;
            if (indexed_vertices.size() == 0) begin
                $error("result with no vertex pending: vertex_index %0d", got.vertex_index);
                mismatches++;
            end else begin
                want = indexed_vertices.pop_front();
                check_field("vertex_index", 64'(want.vertex_index), 64'(got.vertex_index));
                check_field("is_new", 64'(want.is_new), 64'(got.is_new));
                check_field("table_full", 64'(want.table_full), 64'(got.table_full));
                check_field("tangent_sum", 64'(want.tangent_sum), 64'(got.tangent_sum));
                check_field("bitangent_sum", 64'(want.bitangent_sum),
                            64'(got.bitangent_sum));
            end
        end
    end

    task automatic send_vertex(input t_vdi_in v, input bit typed, input t_vdi_out typed_want);
        t_vdi_out lookup;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            vtx_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        vtx_bus.valid <= 1'b1;
        vtx_bus.data  <= v;
        do @(posedge i_clk); while (!(vtx_bus.valid && vtx_bus.ready));
        lookup = index_vertex(v);
        if (typed) lookup = typed_want;
        indexed_vertices = {indexed_vertices, lookup};
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        vtx_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (indexed_vertices.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        hold_off();
        wait_drained();
        repeat (8) @(negedge i_clk);
        i_cfg_wdata <= tol;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        match_tol = tol;
    endtask

    task automatic run_directed();
        t_vertex_row row;
        t_vdi_in     v;
        t_comp_vec   c;
        int          n;
        int          k;
        int unsigned r;
        for (n = 0; n < ROW_N; n++) begin
            row = VERTEX_ROWS[n];
            v = '0;
            for (k = 0; k < COMP_N; k++) c[k] = row.base;
            c[row.poke] = row.poke_val;
            v = join_comps(v, c);
            v.mesh_start   = row.start;
            v.tangent_in   = row.tan;
            v.bitangent_in = row.bitan;
            for (r = 0; r < row.reps; r++) send_vertex(v, row.typed, row.want);
        end
    endtask

    task automatic run_random_phase(
        input int unsigned      src_pct,
        input int unsigned      rcv_pct,
        input logic [TOL_W-1:0] tol,
        input int unsigned      items
    );
        t_vdi_in     v;
        int unsigned sent;
        int unsigned r;
        bit          paused;
        bit          up;
        set_tolerance(tol);
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        paused = 1'b0;
        while (sent < items) begin
            if (!paused && sent >= items / 2) begin
                paused = 1'b1;
                hold_off();
                wait_drained();
            end
            if (mesh_pool.size() != 0 && $urandom_range(99) < 3) begin
                v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
                v.mesh_start = 1'b0;
                up = $urandom_range(1);
                v.tangent_in   = up ? {LANE_N{LANE_MAX}} : {LANE_N{LANE_MIN}};
                v.bitangent_in = up ? {LANE_N{LANE_MIN}} : {LANE_N{LANE_MAX}};
                for (r = 0; r < BURST_LEN; r++) send_vertex(v, 1'b0, '0);
                since_start += BURST_LEN;
                sent += BURST_LEN;
            end else begin
                v = random_vertex();
                send_vertex(v, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic run_fill_phase();
        t_vdi_in v;
        t_vdi_in landmark;
        int      n;
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        set_tolerance('0);
        landmark = '0;
        for (n = 0; n < MAX_VERTICES + 2; n++) begin
            v = raw_vertex();
            v.mesh_start = (n == 0);
            if (n == MAX_VERTICES - 24) landmark = v;
            if (n >= MAX_VERTICES) send_vertex(v, 1'b1, FULL_RESULT);
            else send_vertex(v, 1'b0, '0);
        end
        set_tolerance(TOL_W'(1));
        landmark.mesh_start = 1'b0;
        send_vertex(landmark, 1'b0, '0);
        send_vertex(raw_vertex(), 1'b0, '0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        vtx_bus.valid = 1'b0;
        vtx_bus.data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random_phase(20, 71, TOL_W'($urandom_range(40000, 2)), 194);
        run_random_phase(71, 20, TOL_MAX, 193);
        run_random_phase(0, 0, TOL_W'(1), 193);
        run_fill_phase();
        hold_off();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && indexed_vertices.size() == 0)
            $display("vertex_dedup_indexer_core test passed");
        else
            $display("vertex_dedup_indexer_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
